// ----- hw/rtl/led_strip_frame_buffer_engine_core_defines.svh -----
// Assertion helpers for the LED strip engine.
`ifndef LED_STRIP_FRAME_BUFFER_ENGINE_CORE_DEFINES_SVH
`define LED_STRIP_FRAME_BUFFER_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define LSFBE_ASSERT_IMPL(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lsfbe check failed");

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define LSFBE_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lsfbe check failed");

`endif

// ----- hw/rtl/lsfbe_pkg.sv -----
package lsfbe_pkg;

    localparam int LED_COUNT_DEF = 32;
    localparam int IDX_W         = 8;
    localparam int DIV_STEPS     = 8;

    localparam logic [7:0]  HEAD_MARK  = 8'hE0;
    localparam logic [31:0] START_WORD = 32'h0000_0000;
    localparam logic [31:0] END_WORD   = 32'hFFFF_FFFF;
    localparam logic [7:0]  LEVEL_MAX  = 8'hFF;

    typedef enum logic [2:0] {
        REQ_SET_RANGE    = 3'd0,
        REQ_SHIFT_ENDS   = 3'd1,
        REQ_SHIFT_CENTER = 3'd2,
        REQ_FADE         = 3'd3,
        REQ_CLOUD        = 3'd4,
        REQ_SEND_FRAME   = 3'd5
    } req_code_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [5:0]        range_first;
        logic [5:0]        range_last;
        logic              direction;
        logic [8:0]        fade_factor;
        logic signed [7:0] cloud_center;
        logic [4:0]        cloud_width;
        logic [7:0]        red_level;
        logic [7:0]        green_level;
        logic [7:0]        blue_level;
    } req_t;

    typedef struct packed {
        logic [31:0] frame_word;
        logic        last_word;
    } word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEG_LOAD,
        ST_CHECK,
        ST_DIV,
        ST_READ,
        ST_WRITE,
        ST_F_START,
        ST_F_READ,
        ST_F_LOAD,
        ST_F_END
    } state_t;

    typedef enum logic [1:0] {
        K_COPY,
        K_PUT,
        K_FADE,
        K_BLEND
    } kind_t;

    // Exact floor(x / 255) for x up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x >> 8) + 17'd1;
        return t[15:8];
    endfunction

    // old * f / 256 + col * (256 - f) / 256, each quotient toward zero, clamped.
    function automatic logic [7:0] fade_one(input logic [7:0] old, input logic [8:0] f,
                                            input logic [7:0] col);
        logic [16:0]        pa;
        logic signed [9:0]  nw;
        logic signed [18:0] pb;
        logic [18:0]        mag;
        logic [10:0]        mq;
        logic signed [10:0] qb;
        logic signed [11:0] s;
        pa  = 17'(old) * 17'(f);
        nw  = 10'sd256 - $signed({1'b0, f});
        pb  = 19'($signed({1'b0, col})) * 19'(nw);
        mag = pb[18] ? 19'(-pb) : 19'(pb);
        mq  = 11'(mag >> 8);
        qb  = pb[18] ? -$signed(mq) : $signed(mq);
        s   = $signed({3'b000, pa[16:8]}) + 12'(qb);
        if (s < 0) begin
            return 8'd0;
        end
        if (s > 12'sd255) begin
            return LEVEL_MAX;
        end
        return s[7:0];
    endfunction

    function automatic logic [7:0] blend_one(input logic [7:0] col, input logic [7:0] w,
                                             input logic [7:0] old);
        logic [15:0] p1;
        logic [15:0] p2;
        p1 = 16'(col) * 16'(w);
        p2 = 16'(old) * 16'(LEVEL_MAX - w);
        if (w == 8'd0) begin
            return old;
        end
        if (w == LEVEL_MAX) begin
            return col;
        end
        return div255(p1) + div255(p2);
    endfunction

endpackage

// ----- hw/rtl/lsfbe_ifs.sv -----
interface lsfbe_req_if;
    import lsfbe_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lsfbe_word_if;
    import lsfbe_pkg::*;
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/led_strip_frame_buffer_engine_core.sv -----
// Channel   | Dir | Carries
// req       | in  | one request word: operation code, range, direction, fade, cloud, colour
// frame     | out | one 32-bit frame word with a last_word flag
// cfg_we    | in  | write strobe for the five-bit global brightness (cfg_wdata)
//
// Requests are taken one at a time; ready is high only while the engine is idle.
// Each LED touched passes through an index check, a memory read and a write back; a cloud LED
// first adds the bit-serial weight division, which runs before the memory read.
// A frame takes LED_COUNT + 2 words; each LED word is read from memory before it is loaded.
// Reset clears the per-LED valid bits at once, so the strip reads as black; no sweep.
// A stalled frame word holds the sequencer; a new request is taken while the end word waits.
`include "led_strip_frame_buffer_engine_core_defines.svh"

module led_strip_frame_buffer_engine_core #(
    parameter int LED_COUNT = lsfbe_pkg::LED_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [4:0]   cfg_wdata,
    lsfbe_req_if.sink    req,
    lsfbe_word_if.source frame
);
    import lsfbe_pkg::*;

    localparam int AW     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CENTER = LED_COUNT / 2;
    localparam logic signed [IDX_W-1:0] I_LAST   = IDX_W'(LED_COUNT - 1);
    localparam logic signed [IDX_W-1:0] I_LAST2  = IDX_W'(LED_COUNT - 2);
    localparam logic signed [IDX_W-1:0] I_CENTER = IDX_W'(CENTER);
    localparam logic signed [IDX_W-1:0] I_CUP    = IDX_W'(CENTER + 1);
    localparam logic signed [IDX_W-1:0] I_CDN    = IDX_W'(CENTER - 1);

    state_t                   state_reg, state_next;
    logic [2:0]               sub_reg, sub_next;
    logic signed [IDX_W-1:0]  idx_reg, idx_next;
    req_t                     cmd_reg, cmd_next;
    logic [4:0]               gb_reg;
    logic [17:0]              rem_reg, rem_next;
    logic [17:0]              den_reg, den_next;
    logic [7:0]               quo_reg, quo_next;
    logic [2:0]               cnt_reg, cnt_next;
    word_t                    out_reg;
    logic                     out_valid_reg;

    logic [23:0]              mem [LED_COUNT];
    logic [LED_COUNT-1:0]     valid_reg;
    logic [23:0]              rd_data_reg;
    logic                     rd_valid_reg;

    // Segment descriptor of the current request and sub-loop.
    logic                     seg_ok;
    logic signed [IDX_W-1:0]  seg_start, seg_lim;
    logic                     seg_down;
    kind_t                    seg_kind;
    logic signed [1:0]        seg_off;

    logic signed [9:0]        cl_lo, cl_hi, pos10, w2;
    logic signed [IDX_W-1:0]  set_lim, cl_start, cl_lim;
    logic                     in_range;
    logic                     out_free;
    logic                     out_load;
    word_t                    out_word;
    logic                     rd_en, wr_en;
    logic [AW-1:0]            rd_addr, wr_addr;
    logic signed [IDX_W-1:0]  rd_idx;
    logic [23:0]              old_rgb, wr_data, colour;
    logic signed [8:0]        q;
    logic [17:0]              qq, ww, num_init, den_init;
    logic [24:0]              trial;

    assign colour = {cmd_reg.red_level, cmd_reg.green_level, cmd_reg.blue_level};
    assign old_rgb = rd_valid_reg ? rd_data_reg : 24'd0;

    always_comb
    begin
        pos10    = 10'(cmd_reg.cloud_center);
        w2       = $signed({4'b0000, cmd_reg.cloud_width, 1'b0});
        cl_lo    = pos10 - w2;
        cl_hi    = pos10 + w2;
        cl_start = (cl_lo < 0) ? IDX_W'(0) : IDX_W'(cl_lo);
        cl_lim   = (cl_hi > 10'(I_LAST)) ? I_LAST : IDX_W'(cl_hi);
        set_lim  = ($signed({2'b00, cmd_reg.range_last}) > I_LAST) ? I_LAST
                   : $signed({2'b00, cmd_reg.range_last});
    end

    always_comb
    begin
        seg_ok    = 1'b0;
        seg_start = '0;
        seg_lim   = '0;
        seg_down  = 1'b0;
        seg_kind  = K_PUT;
        seg_off   = 2'sd0;
        case (cmd_reg.req_type)
            REQ_SET_RANGE:
            begin
                seg_ok    = (sub_reg == 3'd0);
                seg_start = $signed({2'b00, cmd_reg.range_first});
                seg_lim   = set_lim;
            end
            REQ_SHIFT_ENDS:
            begin
                seg_ok = (sub_reg <= 3'd1);
                if (cmd_reg.direction) begin
                    if (sub_reg == 3'd0) begin
                        seg_start = I_LAST;
                        seg_lim   = IDX_W'(1);
                        seg_down  = 1'b1;
                        seg_kind  = K_COPY;
                        seg_off   = -2'sd1;
                    end
                end else begin
                    if (sub_reg == 3'd0) begin
                        seg_lim  = I_LAST2;
                        seg_kind = K_COPY;
                        seg_off  = 2'sd1;
                    end else begin
                        seg_start = I_LAST;
                        seg_lim   = I_LAST;
                    end
                end
            end
            REQ_SHIFT_CENTER:
            begin
                if (cmd_reg.direction) begin
                    seg_ok = (sub_reg <= 3'd2);
                    case (sub_reg)
                        3'd0:
                        begin
                            seg_start = I_LAST;
                            seg_lim   = I_CUP;
                            seg_down  = 1'b1;
                            seg_kind  = K_COPY;
                            seg_off   = -2'sd1;
                        end
                        3'd1:
                        begin
                            seg_lim  = I_CDN;
                            seg_kind = K_COPY;
                            seg_off  = 2'sd1;
                        end
                        default:
                        begin
                            seg_start = I_CENTER;
                            seg_lim   = I_CENTER;
                        end
                    endcase
                end else begin
                    seg_ok = (sub_reg <= 3'd3);
                    case (sub_reg)
                        3'd0:
                        begin
                            seg_start = I_CENTER;
                            seg_lim   = I_LAST2;
                            seg_kind  = K_COPY;
                            seg_off   = 2'sd1;
                        end
                        3'd1:
                        begin
                            seg_start = I_CENTER;
                            seg_lim   = IDX_W'(1);
                            seg_down  = 1'b1;
                            seg_kind  = K_COPY;
                            seg_off   = -2'sd1;
                        end
                        3'd2:
                        begin
                            seg_lim = '0;
                        end
                        default:
                        begin
                            seg_start = I_LAST;
                            seg_lim   = I_LAST;
                        end
                    endcase
                end
            end
            REQ_FADE:
            begin
                seg_ok   = (sub_reg == 3'd0);
                seg_lim  = I_LAST;
                seg_kind = K_FADE;
            end
            REQ_CLOUD:
            begin
                seg_ok    = (sub_reg == 3'd0) && (cmd_reg.cloud_width != 5'd0);
                seg_start = cl_start;
                seg_lim   = cl_lim;
                seg_kind  = K_BLEND;
            end
            default:
            begin
                seg_ok = 1'b0;
            end
        endcase
    end

    assign in_range = seg_down ? (idx_reg >= seg_lim) : (idx_reg <= seg_lim);
    assign out_free = !out_valid_reg || frame.ready;

    // Cloud weight operands: width^2 * 255 over 5 * q^2 + width^2.
    always_comb
    begin
        q        = 9'(idx_reg) - 9'(cmd_reg.cloud_center);
        qq       = 18'(q) * 18'(q);
        ww       = 18'(cmd_reg.cloud_width) * 18'(cmd_reg.cloud_width);
        num_init = (ww << 8) - ww;
        den_init = (qq << 2) + qq + ww;
        trial    = 25'(den_reg) << cnt_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        sub_next   = sub_reg;
        idx_next   = idx_reg;
        cmd_next   = cmd_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid) begin
                    cmd_next = req.data;
                    sub_next = 3'd0;
                    idx_next = '0;
                    if (req.data.req_type == REQ_SEND_FRAME) begin
                        state_next = ST_F_START;
                    end else begin
                        state_next = ST_SEG_LOAD;
                    end
                end
            end
            ST_SEG_LOAD:
            begin
                if (seg_ok) begin
                    idx_next   = seg_start;
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (!in_range) begin
                    sub_next   = sub_reg + 3'd1;
                    state_next = ST_SEG_LOAD;
                end else if (seg_kind == K_BLEND) begin
                    rem_next   = num_init;
                    den_next   = den_init;
                    quo_next   = '0;
                    cnt_next   = 3'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_DIV:
            begin
                if (25'(rem_reg) >= trial) begin
                    rem_next          = rem_reg - trial[17:0];
                    quo_next[cnt_reg] = 1'b1;
                end
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                idx_next   = seg_down ? idx_reg - IDX_W'(1) : idx_reg + IDX_W'(1);
                state_next = ST_CHECK;
            end
            ST_F_START:
            begin
                if (out_free) begin
                    state_next = ST_F_READ;
                end
            end
            ST_F_READ:
            begin
                state_next = ST_F_LOAD;
            end
            ST_F_LOAD:
            begin
                if (out_free) begin
                    if (idx_reg == I_LAST) begin
                        state_next = ST_F_END;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_F_READ;
                    end
                end
            end
            ST_F_END:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
        rd_en     = (state_reg == ST_READ) || (state_reg == ST_F_READ);
        rd_idx    = (state_reg == ST_READ) ? idx_reg + IDX_W'(seg_off) : idx_reg;
        rd_addr   = rd_idx[AW-1:0];
        wr_en     = (state_reg == ST_WRITE);
        wr_addr   = idx_reg[AW-1:0];
        case (seg_kind)
            K_COPY:  wr_data = old_rgb;
            K_PUT:   wr_data = colour;
            K_FADE:  wr_data = {fade_one(old_rgb[23:16], cmd_reg.fade_factor, colour[23:16]),
                                fade_one(old_rgb[15:8], cmd_reg.fade_factor, colour[15:8]),
                                fade_one(old_rgb[7:0], cmd_reg.fade_factor, colour[7:0])};
            K_BLEND: wr_data = {blend_one(colour[23:16], quo_reg, old_rgb[23:16]),
                                blend_one(colour[15:8], quo_reg, old_rgb[15:8]),
                                blend_one(colour[7:0], quo_reg, old_rgb[7:0])};
            default: wr_data = old_rgb;
        endcase
        out_load = 1'b0;
        out_word = '{frame_word: START_WORD, last_word: 1'b0};
        case (state_reg)
            ST_F_START:
            begin
                out_load = out_free;
            end
            ST_F_LOAD:
            begin
                out_load = out_free;
                out_word = '{frame_word: {HEAD_MARK | {3'b000, gb_reg}, old_rgb[7:0],
                                          old_rgb[15:8], old_rgb[23:16]},
                             last_word: 1'b0};
            end
            ST_F_END:
            begin
                out_load = out_free;
                out_word = '{frame_word: END_WORD, last_word: 1'b1};
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    assign frame.valid = out_valid_reg;
    assign frame.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            sub_reg       <= '0;
            idx_reg       <= '0;
            gb_reg        <= 5'd1;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
        end else begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            if (cfg_we) begin
                gb_reg <= cfg_wdata;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (frame.ready) begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        if (out_load) begin
            out_reg <= out_word;
        end
    end

    // LED colour memory, one word of red, green and blue per LED.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    `LSFBE_ASSERT_IMPL(a_write_in_strip, state_reg == ST_WRITE, idx_reg >= 0 && idx_reg <= I_LAST)
    `LSFBE_ASSERT_NEXT(a_div_done, state_reg == ST_DIV && cnt_reg == 3'd0, state_reg == ST_READ)
    `LSFBE_ASSERT_IMPL(a_end_word_after_frame, frame.valid && frame.ready && frame.data.last_word, state_reg != ST_F_READ && state_reg != ST_F_LOAD && state_reg != ST_F_END)

endmodule
